@@ rtl/lz_byte_window_decompressor_unit_assert.svh @@
// assertion macros for the lz byte window decompressor
`ifndef LZ_BYTE_WINDOW_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZ_BYTE_WINDOW_DECOMPRESSOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define LZBWD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzbwd same-cycle check failed");
`define LZBWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzbwd next-cycle check failed");
`else
`define LZBWD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LZBWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/lzbwd_pkg.sv @@
package lzbwd_pkg;

    localparam int LANES      = 4;
    localparam int LANE_W     = $clog2(LANES);
    localparam int K_W        = $clog2(LANES + 1);
    localparam int HIST_DEPTH = 256;
    localparam int PTR_W      = $clog2(HIST_DEPTH);
    localparam int PROD_W     = PTR_W + 1;

    localparam logic [7:0] CMD_END     = 8'h00;
    localparam logic [7:0] LEN_MASK    = 8'h7F;
    localparam logic [7:0] LEN_BIAS    = 8'd3;
    localparam logic [8:0] DIST_BIAS   = 9'd1;

    typedef logic [7:0] t_byte;

    typedef enum logic [1:0] {
        PH_CMD  = 2'd0,
        PH_LIT  = 2'd1,
        PH_DIST = 2'd2,
        PH_END  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RD    = 2'd1,
        ST_WR    = 2'd2,
        ST_FLUSH = 2'd3
    } t_state;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_stream;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
        logic [7:0] out_byte3;
        logic [2:0] out_count;
        logic       run_last;
        logic       stream_end;
    } t_out_item;

endpackage

@@ rtl/lz_byte_window_decompressor_unit.sv @@
// channel | direction | handshake                | word
// in      | to block  | i_in_valid / o_in_stall  | t_in_item  (in_byte, new_stream)
// out     | from block| o_out_valid / i_out_stall| t_out_item (four bytes, count, flags)
//
// command, literal and terminator words are each handled as they are taken, without leaving idle
// after its distance word, a back-reference of len bytes holds the input until its
// last packed word is handed off: every byte is a registered history read (ST_RD) then a
// write-back (ST_WR), and each packed word of up to four bytes is handed off in ST_FLUSH
// reset clears the parser, write pointer, produced count and output valid; history is not cleared
// a stalled output word holds the output register and blocks both new input and the next handoff
`include "lz_byte_window_decompressor_unit_assert.svh"

module lz_byte_window_decompressor_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  lzbwd_pkg::t_in_item  i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output lzbwd_pkg::t_out_item o_out_data,
    input  logic                 i_out_stall
);
    import lzbwd_pkg::*;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [6:0]        r_lit, n_lit;
    logic [7:0]        r_copy_len, n_copy_len;
    logic [8:0]        r_dist, n_dist;
    logic [7:0]        r_left, n_left;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [K_W-1:0]    r_k, n_k;
    t_byte             r_lane [LANES];
    t_byte             n_lane [LANES];
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              out_free;
    logic              in_take;
    t_phase            ph_eff;
    logic [PTR_W-1:0]  wp_eff;
    logic [PROD_W-1:0] prod_eff;
    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    t_byte             mem_wdata;
    logic [PTR_W-1:0]  mem_raddr;
    t_byte             mem_rdata;
    t_byte             copy_byte;
    t_byte             b;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign b        = i_in_data.in_byte;
    assign ph_eff   = i_in_data.new_stream ? PH_CMD : r_phase;
    assign wp_eff   = i_in_data.new_stream ? '0 : r_wp;
    assign prod_eff = i_in_data.new_stream ? '0 : r_prod;

    // source position wraps around the window; distance 256 lands on the write slot
    assign mem_raddr = r_wp - r_dist[PTR_W-1:0];
    // reach before the start of the stream reads as zero
    assign copy_byte = (r_dist <= r_prod) ? mem_rdata : 8'h00;

    lzbwd_hist_ram u_hist (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_CMD;
            r_lit       <= '0;
            r_copy_len  <= '0;
            r_left      <= '0;
            r_wp        <= '0;
            r_prod      <= '0;
            r_k         <= '0;
            r_lane      <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_lit       <= n_lit;
            r_copy_len  <= n_copy_len;
            r_left      <= n_left;
            r_wp        <= n_wp;
            r_prod      <= n_prod;
            r_k         <= n_k;
            r_lane      <= n_lane;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_lit       = r_lit;
        n_copy_len  = r_copy_len;
        n_dist      = r_dist;
        n_left      = r_left;
        n_wp        = r_wp;
        n_prod      = r_prod;
        n_k         = r_k;
        n_lane      = r_lane;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_waddr   = r_wp;
        mem_wdata   = copy_byte;

        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_wp   = wp_eff;
                    n_prod = prod_eff;
                    if (i_in_data.new_stream) begin
                        n_lit      = '0;
                        n_copy_len = '0;
                    end
                    case (ph_eff)
                        PH_CMD: begin
                            if (b == CMD_END) begin
                                n_out            = '0;
                                n_out.run_last   = 1'b1;
                                n_out.stream_end = 1'b1;
                                n_out_valid      = 1'b1;
                                n_phase          = PH_END;
                            end else if (b[7]) begin
                                n_copy_len = (b & LEN_MASK) + LEN_BIAS;
                                n_phase    = PH_DIST;
                            end else begin
                                n_lit   = b[6:0];
                                n_phase = PH_LIT;
                            end
                        end
                        PH_LIT: begin
                            mem_we          = 1'b1;
                            mem_waddr       = wp_eff;
                            mem_wdata       = b;
                            n_wp            = wp_eff + 1'b1;
                            n_prod          = (prod_eff == PROD_W'(HIST_DEPTH)) ?
                                              prod_eff : prod_eff + 1'b1;
                            n_out           = '0;
                            n_out.out_byte0 = b;
                            n_out.out_count = 3'd1;
                            n_out.run_last  = 1'b1;
                            n_out_valid     = 1'b1;
                            if (r_lit != '0) begin
                                n_lit = r_lit - 1'b1;
                            end
                            if (r_lit <= 7'd1) begin
                                n_phase = PH_CMD;
                            end
                        end
                        PH_DIST: begin
                            n_dist  = {1'b0, b} + DIST_BIAS;
                            n_left  = r_copy_len;
                            n_k     = '0;
                            n_state = ST_RD;
                        end
                        PH_END: begin
                            // bytes after the terminator are dropped
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD: begin
                n_state = ST_WR;
            end
            ST_WR: begin
                mem_we                 = 1'b1;
                n_lane[r_k[LANE_W-1:0]] = copy_byte;
                n_k                    = r_k + 1'b1;
                n_wp                   = r_wp + 1'b1;
                n_prod                 = (r_prod == PROD_W'(HIST_DEPTH)) ? r_prod : r_prod + 1'b1;
                n_left                 = r_left - 1'b1;
                if ((r_k + 1'b1) == K_W'(LANES) || r_left == 8'd1) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out.out_byte0  = r_lane[0];
                    n_out.out_byte1  = r_lane[1];
                    n_out.out_byte2  = r_lane[2];
                    n_out.out_byte3  = r_lane[3];
                    n_out.out_count  = 3'(r_k);
                    n_out.run_last   = (r_left == '0);
                    n_out.stream_end = 1'b0;
                    n_out_valid      = 1'b1;
                    n_k              = '0;
                    for (int i = 0; i < LANES; i++) begin
                        n_lane[i] = 8'h00;
                    end
                    if (r_left == '0) begin
                        n_state    = ST_IDLE;
                        n_phase    = PH_CMD;
                        n_copy_len = '0;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LZBWD_ASSERT_NOW(a_end_word_empty, i_clk, i_rst_n, o_out_valid && o_out_data.stream_end, o_out_data.out_count == 3'd0 && o_out_data.run_last)
    `LZBWD_ASSERT_NOW(a_lane_in_range, i_clk, i_rst_n, r_state == ST_WR, r_k < K_W'(LANES))
    `LZBWD_ASSERT_NEXT(a_last_flush_idle, i_clk, i_rst_n, r_state == ST_FLUSH && out_free && r_left == '0, r_state == ST_IDLE && o_out_valid && o_out_data.run_last)

endmodule

@@ rtl/lzbwd_hist_ram.sv @@
module lzbwd_hist_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [lzbwd_pkg::PTR_W-1:0] i_waddr,
    input  lzbwd_pkg::t_byte          i_wdata,
    input  logic [lzbwd_pkg::PTR_W-1:0] i_raddr,
    output lzbwd_pkg::t_byte          o_rdata
);
    import lzbwd_pkg::*;

    t_byte r_mem [HIST_DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ bench/lz_byte_window_decompressor_unit_test.sv @@
module lz_byte_window_decompressor_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lzbwd_pkg::*;

    class lz_window_tracker;
        t_phase            phase    = PH_CMD;
        logic [6:0]        lit_left = '0;
        logic [7:0]        copy_len = '0;
        t_byte             hist [HIST_DEPTH];
        logic [PTR_W-1:0]  wr_ptr   = '0;
        logic [PROD_W-1:0] produced = '0;
        t_out_item         due [$];
        int                errors   = 0;

        function void store(t_byte v);
            hist[wr_ptr] = v;
            wr_ptr++;
            if (produced < HIST_DEPTH) produced++;
        endfunction

        // work out every word one accepted input byte should produce
        function void take_word(t_in_item w);
            t_byte            b;
            t_byte            lane [4];
            t_out_item        r;
            logic [8:0]       reach;
            logic [PTR_W-1:0] rd_at;
            int               n;
            int               k;
            int               lanes;
            b = w.in_byte;
            if (w.new_stream) begin
                phase    = PH_CMD;
                lit_left = '0;
                copy_len = '0;
                wr_ptr   = '0;
                produced = '0;
            end
            case (phase)
                PH_CMD: begin
                    if (b == CMD_END) begin
                        r = '0;
                        r.run_last   = 1'b1;
                        r.stream_end = 1'b1;
                        due.push_back(r);
                        phase = PH_END;
                    end else if (b[7]) begin
                        copy_len = (b & LEN_MASK) + LEN_BIAS;
                        phase    = PH_DIST;
                    end else begin
                        lit_left = b[6:0];
                        phase    = PH_LIT;
                    end
                end
                PH_LIT: begin
                    store(b);
                    r = '0;
                    r.out_byte0 = b;
                    r.out_count = 3'd1;
                    r.run_last  = 1'b1;
                    due.push_back(r);
                    if (lit_left > 0) lit_left--;
                    if (lit_left == 0) phase = PH_CMD;
                end
                PH_DIST: begin
                    reach = {1'b0, b} + DIST_BIAS;
                    lanes = (LANES > 4) ? 4 : LANES;
                    n     = 0;
                    while (n < copy_len) begin
                        foreach (lane[i]) lane[i] = '0;
                        k = 0;
                        // one byte at a time so overlapping copies repeat the pattern
                        while (k < lanes && n < copy_len) begin
                            rd_at   = wr_ptr - reach[7:0];
                            lane[k] = (reach <= produced) ? hist[rd_at] : '0;
                            store(lane[k]);
                            k++;
                            n++;
                        end
                        r = '0;
                        r.out_byte0 = lane[0];
                        r.out_byte1 = lane[1];
                        r.out_byte2 = lane[2];
                        r.out_byte3 = lane[3];
                        r.out_count = k[2:0];
                        r.run_last  = (n == copy_len);
                        due.push_back(r);
                    end
                    copy_len = '0;
                    phase    = PH_CMD;
                end
                default: ;
            endcase
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void match_word(t_out_item got);
            t_out_item want;
            if (due.size() == 0) begin
                $error("output word with nothing expected: %h", got);
                errors++;
                return;
            end
            want = due.pop_front();
            compare("out_byte0", want.out_byte0, got.out_byte0);
            compare("out_byte1", want.out_byte1, got.out_byte1);
            compare("out_byte2", want.out_byte2, got.out_byte2);
            compare("out_byte3", want.out_byte3, got.out_byte3);
            compare("out_count", want.out_count, got.out_count);
            compare("run_last", want.run_last, got.run_last);
            compare("stream_end", want.stream_end, got.stream_end);
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall = 1'b0;

    lz_window_tracker track = new();
    bit calm = 1'b0;
    int sent = 0;

    lz_byte_window_decompressor_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 12);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) track.match_word(o_out_data);
    end

    // entered and left at a falling edge
    task automatic send_word(input t_byte b, input logic ns, input int counts);
        t_in_item w;
        w.in_byte    = b;
        w.new_stream = ns;
        while (!calm && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
        track.take_word(w);
        sent += counts;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (track.due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_stream();
        int   cmds;
        int   c;
        int   i;
        int   n;
        logic ns;
        cmds = $urandom_range(1, 8);
        ns   = 1'b1;
        for (c = 0; c < cmds; c++) begin
            if ($urandom_range(99) < 55) begin
                if ($urandom_range(99) < 4) n = 127;
                else if ($urandom_range(99) < 10) n = $urandom_range(1, 127);
                else n = $urandom_range(1, 6);
                send_word(t_byte'(n), ns, 1);
                ns = 1'b0;
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(99) < 1) return;
                    send_word(t_byte'($urandom_range(255)), 1'b0, 1);
                end
            end else begin
                n = ($urandom_range(99) < 10) ? $urandom_range(0, 127) : $urandom_range(0, 7);
                send_word(t_byte'(8'h80 | n), ns, 1);
                ns = 1'b0;
                if ($urandom_range(99) < 3) return;
                n = ($urandom_range(99) < 70) ? $urandom_range(0, 15) : $urandom_range(0, 255);
                send_word(t_byte'(n), 1'b0, 1);
            end
        end
        // some streams are cut short and never see a terminator
        if ($urandom_range(99) < 8) return;
        send_word(CMD_END, ns, 1);
        repeat ($urandom_range(0, 2)) send_word(t_byte'($urandom_range(255)), 1'b0, 1);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            send_word(t_byte'($urandom_range(255)), $urandom_range(99) < 25, 1);
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // terminator right at the start, then a byte after the end
        send_word(CMD_END, 1'b1, 1);
        send_word(8'h42, 1'b0, 1);
        // literals at the byte extremes
        send_word(8'h03, 1'b1, 1);
        send_word(8'hFF, 1'b0, 1);
        send_word(8'h00, 1'b0, 1);
        send_word(8'h80, 1'b0, 1);
        // overlapping copy at distance one
        send_word(8'h80, 1'b0, 1);
        send_word(8'h00, 1'b0, 1);
        // reach past the start of the stream
        send_word(8'h85, 1'b0, 1);
        send_word(8'hFF, 1'b0, 1);
        // distance equal to the bytes produced so far
        send_word(8'h81, 1'b0, 1);
        send_word(8'h0D, 1'b0, 1);
        // longest copies, wrapping the window and saturating the count
        send_word(8'hFF, 1'b0, 1);
        send_word(8'h04, 1'b0, 1);
        send_word(8'hFF, 1'b0, 1);
        send_word(8'h80, 1'b0, 1);
        send_word(8'h82, 1'b0, 1);
        send_word(8'hFF, 1'b0, 1);
        send_word(CMD_END, 1'b0, 1);
        // new stream: old history must stay out of reach
        send_word(8'h81, 1'b1, 1);
        send_word(8'h00, 1'b0, 1);
        // restart in the middle of a literal run
        send_word(8'h02, 1'b0, 1);
        send_word(8'h55, 1'b0, 1);
        send_word(8'h90, 1'b1, 1);
        send_word(8'h02, 1'b0, 1);
        send_word(CMD_END, 1'b0, 1);
        drain();

        while (sent < 320) begin
            calm = (sent >= 150 && sent < 210);
            if (!paused && sent >= 240) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 15) send_noise();
            else send_stream();
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (track.due.size() != 0) @(posedge i_clk);
        repeat (320) @(posedge i_clk);
        if (track.errors == 0) begin
            $display("lz_byte_window_decompressor_unit_test: done, clean");
        end else begin
            $display("lz_byte_window_decompressor_unit_test: done, errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("lz_byte_window_decompressor_unit_test: done, errors");
        $finish;
    end

endmodule
